>>> rtl/core/bdpc_pkg.sv
// ----------------------------------------------------------------------------
// bdpc_pkg
// Shared types and constants for the button debounce and press classifier.
// ----------------------------------------------------------------------------
package bdpc_pkg;

  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned TICKS_W     = 16;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_INVERT_INPUT     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE_TICKS   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_LONG_PRESS_TICKS = 2'd2;

  // Reset values of the configuration registers
  localparam logic               RST_INVERT_INPUT     = 1'b1;
  localparam logic [TICKS_W-1:0] RST_DEBOUNCE_TICKS   = 16'd80;
  localparam logic [TICKS_W-1:0] RST_LONG_PRESS_TICKS = 16'd1000;

  // Released level of the adjusted sample
  localparam logic LEVEL_RELEASED = 1'b1;
  localparam logic LEVEL_PRESSED  = 1'b0;

  typedef enum logic [1:0] {
    EVT_NONE  = 2'd0,
    EVT_SHORT = 2'd1,
    EVT_LONG  = 2'd2
  } press_evt_t;

  typedef struct packed {
    logic               invert_input;
    logic [TICKS_W-1:0] debounce_ticks;
    logic [TICKS_W-1:0] long_press_ticks;
  } cfg_t;

endpackage

>>> rtl/core/bdpc_cfg_regs.sv
// ----------------------------------------------------------------------------
// bdpc_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module bdpc_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [bdpc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bdpc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output bdpc_pkg::cfg_t                   cfg
);
  import bdpc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.invert_input     <= RST_INVERT_INPUT;
      cfg.debounce_ticks   <= RST_DEBOUNCE_TICKS;
      cfg.long_press_ticks <= RST_LONG_PRESS_TICKS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INVERT_INPUT:     cfg.invert_input     <= cfg_data[0];
        CFG_DEBOUNCE_TICKS:   cfg.debounce_ticks   <= cfg_data[TICKS_W-1:0];
        CFG_LONG_PRESS_TICKS: cfg.long_press_ticks <= cfg_data[TICKS_W-1:0];
        default: ; // unused index: drop the write
      endcase
    end
  end

endmodule

>>> rtl/core/bdpc_tracker.sv
// ----------------------------------------------------------------------------
// bdpc_tracker
// Debounce state, hold and press timers, and press classification for one
// tick per step.
// ----------------------------------------------------------------------------
module bdpc_tracker #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic                 raw_level,
  input  bdpc_pkg::cfg_t       cfg,
  output bdpc_pkg::press_evt_t event_next,
  output logic                 level_next
);
  import bdpc_pkg::*;

  localparam int unsigned CMP_W = (TIMER_BITS > TICKS_W) ? TIMER_BITS : TICKS_W;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

  logic                  previous_sample;
  logic                  debounced_level;
  logic                  pressed_flag;
  logic [TIMER_BITS-1:0] hold_counter;
  logic [TIMER_BITS-1:0] press_counter;

  logic                  previous_sample_next;
  logic                  debounced_level_next;
  logic                  pressed_flag_next;
  logic [TIMER_BITS-1:0] hold_counter_next;
  logic [TIMER_BITS-1:0] press_counter_next;

  logic                  sample;
  logic [TIMER_BITS-1:0] press_inc;
  logic                  accept_level;

  always_comb begin
    sample = raw_level ^ cfg.invert_input;

    press_inc = press_counter;
    if (pressed_flag && press_counter != TIMER_MAX) begin
      press_inc = press_counter + 1'b1;
    end

    previous_sample_next = sample;
    if (sample != previous_sample) begin
      hold_counter_next = '0;
    end else if (hold_counter != TIMER_MAX) begin
      hold_counter_next = hold_counter + 1'b1;
    end else begin
      hold_counter_next = hold_counter;
    end

    accept_level = (CMP_W'(hold_counter_next) > CMP_W'(cfg.debounce_ticks)) &&
                   (sample != debounced_level);

    debounced_level_next = debounced_level;
    pressed_flag_next    = pressed_flag;
    press_counter_next   = press_inc;
    event_next           = EVT_NONE;
    if (accept_level) begin
      debounced_level_next = sample;
      if (sample == LEVEL_PRESSED && !pressed_flag) begin
        pressed_flag_next  = 1'b1;
        press_counter_next = '0;
      end else if (sample == LEVEL_RELEASED && pressed_flag) begin
        pressed_flag_next = 1'b0;
        event_next = (CMP_W'(press_inc) >= CMP_W'(cfg.long_press_ticks)) ?
                     EVT_LONG : EVT_SHORT;
      end
    end

    level_next = debounced_level_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_sample <= LEVEL_RELEASED;
      debounced_level <= LEVEL_RELEASED;
      pressed_flag    <= 1'b0;
      hold_counter    <= '0;
      press_counter   <= '0;
    end else if (step) begin
      previous_sample <= previous_sample_next;
      debounced_level <= debounced_level_next;
      pressed_flag    <= pressed_flag_next;
      hold_counter    <= hold_counter_next;
      press_counter   <= press_counter_next;
    end
  end

endmodule

>>> rtl/core/button_debounce_press_classifier.sv
// Button debouncer with short and long press classification. Each transfer
// on the raw channel is one millisecond tick carrying the raw pin level; each
// tick gives exactly one transfer on the result channel, in order, carrying
// the debounced level (0 means pressed) and a press event (none, short or
// long) raised on the tick at which a press is released. The block takes one
// tick per clock cycle while the result channel does not stall; the work for
// a tick is a single pass of comparisons and timer updates between the input
// register and the result register. The result register loads a tick's
// result from the input register once it has room, so ticks may follow back
// to back while the result channel keeps moving. The timers are TIMER_BITS
// wide and saturate. Write configuration only while no tick is in flight.
// ----------------------------------------------------------------------------
// button_debounce_press_classifier
// Top level: input register, tracker, result register and configuration.
// ----------------------------------------------------------------------------
module button_debounce_press_classifier #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration write port
  input  logic                             cfg_we,
  input  logic [bdpc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bdpc_pkg::CFG_DATA_W-1:0]  cfg_data,
  // raw sample channel
  input  logic                             raw_valid,
  output logic                             raw_stall,
  input  logic                             raw_level,
  // result channel
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic [1:0]                       press_event,
  output logic                             stable_level
);
  import bdpc_pkg::*;

  cfg_t       cfg;
  logic       sample_valid;
  logic       sample_level;
  logic       advance;
  logic       step;
  press_evt_t event_next;
  logic       level_next;

  bdpc_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The result register can take a new value when empty or being drained.
  assign advance   = !result_valid || !result_stall;
  // A held tick moves on into the tracker only when its result has room.
  assign step      = sample_valid && advance;
  // Hold off the raw side only while the input register is full and stuck.
  assign raw_stall = sample_valid && !advance;

  // Input register: capture a tick on every raw transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (!raw_stall) begin
      sample_valid <= raw_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!raw_stall && raw_valid) begin
      sample_level <= raw_level;
    end
  end

  bdpc_tracker #(
    .TIMER_BITS (TIMER_BITS)
  ) u_tracker (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .raw_level  (sample_level),
    .cfg        (cfg),
    .event_next (event_next),
    .level_next (level_next)
  );

  // Result register: load on each step, hold while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      press_event  <= event_next;
      stable_level <= level_next;
    end
  end

endmodule

>>> test/bdpc_checker.sv
// ----------------------------------------------------------------------------
// bdpc_checker
// Watches the configuration port and both channels of the button debouncer,
// predicts each tick's result and compares it with what the block returns.
// ----------------------------------------------------------------------------
module bdpc_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [bdpc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bdpc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             raw_valid,
  input  logic                             raw_stall,
  input  logic                             raw_level,
  input  logic                             result_valid,
  input  logic                             result_stall,
  input  logic [1:0]                       press_event,
  input  logic                             stable_level,
  output int unsigned                      mismatch_count,
  output int unsigned                      pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import bdpc_pkg::*;

  localparam logic [TICKS_W-1:0] TIMER_ALL_ONES = '1;
  localparam int unsigned        REPORT_LIMIT   = 10;

  typedef struct packed {
    press_evt_t evt;
    logic       level;
  } tick_result_t;

  tick_result_t       tick_results_q[$];
  cfg_t               cfg_shadow;
  logic               last_sample;
  logic               settled_level;
  logic               in_press;
  logic [TICKS_W-1:0] hold_ticks;
  logic [TICKS_W-1:0] press_ticks;
  int unsigned        fail_tally = 0;

  function automatic logic [TICKS_W-1:0] sat_bump(input logic [TICKS_W-1:0] v);
    return (v == TIMER_ALL_ONES) ? v : v + 1'b1;
  endfunction

  // Advance the debouncer by one tick and return what the block should report.
  function automatic tick_result_t debounce_tick(input logic raw);
    tick_result_t res;
    logic         sample;
    sample  = raw ^ cfg_shadow.invert_input;
    res.evt = EVT_NONE;
    if (in_press) press_ticks = sat_bump(press_ticks);
    if (sample != last_sample) begin
      last_sample = sample;
      hold_ticks  = '0;
    end else begin
      hold_ticks = sat_bump(hold_ticks);
    end
    if (hold_ticks > cfg_shadow.debounce_ticks && sample != settled_level) begin
      settled_level = sample;
      if (sample == LEVEL_PRESSED && !in_press) begin
        in_press    = 1'b1;
        press_ticks = '0;
      end else if (sample == LEVEL_RELEASED && in_press) begin
        in_press = 1'b0;
        res.evt  = (press_ticks >= cfg_shadow.long_press_ticks) ? EVT_LONG : EVT_SHORT;
      end
    end
    res.level = settled_level;
    return res;
  endfunction

  task automatic note_failure(input string what);
    fail_tally++;
    if (fail_tally <= REPORT_LIMIT) $display("%0t ns: %s", $time, what);
  endtask

  always @(posedge clk) begin : watch
    tick_result_t want;
    if (rst) begin
      cfg_shadow.invert_input     = RST_INVERT_INPUT;
      cfg_shadow.debounce_ticks   = RST_DEBOUNCE_TICKS;
      cfg_shadow.long_press_ticks = RST_LONG_PRESS_TICKS;
      last_sample   = LEVEL_RELEASED;
      settled_level = LEVEL_RELEASED;
      in_press      = 1'b0;
      hold_ticks    = '0;
      press_ticks   = '0;
      tick_results_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_INVERT_INPUT:     cfg_shadow.invert_input     = cfg_data[0];
          CFG_DEBOUNCE_TICKS:   cfg_shadow.debounce_ticks   = cfg_data[TICKS_W-1:0];
          CFG_LONG_PRESS_TICKS: cfg_shadow.long_press_ticks = cfg_data[TICKS_W-1:0];
          default: ;
        endcase
      end
      if (raw_valid && !raw_stall) tick_results_q.push_back(debounce_tick(raw_level));
      if (result_valid && !result_stall) begin
        if (tick_results_q.size() == 0) begin
          note_failure($sformatf("result with none awaited: press_event %0d stable_level %0b",
                                 press_event, stable_level));
        end else begin
          want = tick_results_q.pop_front();
          if (press_event !== want.evt || stable_level !== want.level)
            note_failure($sformatf(
              "press_event exp %0d got %0d, stable_level exp %0b got %0b",
              want.evt, press_event, want.level, stable_level));
        end
      end
    end
    mismatch_count <= fail_tally;
    pending        <= tick_results_q.size();
  end

endmodule

>>> test/button_debounce_press_classifier_tb.sv
// ----------------------------------------------------------------------------
// button_debounce_press_classifier_tb
// Drives ticks and configuration into the button debouncer: reset defaults,
// a short directed run, random bounce and press sequences under several
// settings, and the debounce window at its maximum. A checker beside the
// block predicts every result; this module only issues the verdict.
// ----------------------------------------------------------------------------
module button_debounce_press_classifier_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bdpc_pkg::*;

  // Hard stop limit, well above the length of a correct run.
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  // Pipeline holds an input register and a result register; settle margin before touching config.
  localparam int unsigned SETTLE_CYCLES = 4;
  // Index with no register behind it; writes there must be ignored.
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

  logic                   clk          = 1'b0;
  logic                   rst          = 1'b1;
  logic                   cfg_we       = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index    = '0;
  logic [CFG_DATA_W-1:0]  cfg_data     = '0;
  logic                   raw_valid    = 1'b0;
  logic                   raw_level    = 1'b0;
  logic                   result_stall = 1'b0;
  logic                   raw_stall;
  logic                   result_valid;
  logic [1:0]             press_event;
  logic                   stable_level;

  int unsigned mismatch_total;
  int unsigned pending;
  bit          idle_en    = 1'b1;
  int          stall_left = 0;

  always #2 clk = ~clk;

  button_debounce_press_classifier uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .raw_valid    (raw_valid),
    .raw_stall    (raw_stall),
    .raw_level    (raw_level),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .press_event  (press_event),
    .stable_level (stable_level)
  );

  bdpc_checker chk (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .raw_valid      (raw_valid),
    .raw_stall      (raw_stall),
    .raw_level      (raw_level),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .press_event    (press_event),
    .stable_level   (stable_level),
    .mismatch_count (mismatch_total),
    .pending        (pending)
  );

  // Hard stop in case the block hangs or loses a transfer.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Receiver back-pressure: random bursts of stalled cycles, with
  // free-running stretches in between. Drop it entirely once idling is off.
  always @(negedge clk) begin
    if (!idle_en) begin
      result_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      result_stall <= 1'b1;
      stall_left = $urandom_range(0, 13);
    end else begin
      result_stall <= 1'b0;
    end
  end

  // Offer one tick and hold it until the block takes the transfer. A random
  // idle gap may come first while idling is enabled.
  task automatic send_tick(input logic lvl);
    int gap;
    gap = (idle_en && $urandom_range(0, 7) == 0) ? $urandom_range(1, 14) : 0;
    @(negedge clk);
    if (gap > 0) begin
      raw_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    raw_valid <= 1'b1;
    raw_level <= lvl;
    forever begin
      @(posedge clk);
      if (!raw_stall) break;
    end
  endtask

  task automatic send_run(input logic lvl, input int n);
    repeat (n) send_tick(lvl);
  endtask

  // Stop sending and wait until every awaited result has been returned,
  // then let the pipeline settle before anything else happens.
  task automatic drain();
    @(negedge clk) raw_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
  endtask

  // Reprogram every register while the block is idle. Junk goes into the
  // upper bits of the invert register and into the unused index, both of
  // which must be ignored.
  task automatic apply_config(input logic inv, input logic [TICKS_W-1:0] deb,
                              input logic [TICKS_W-1:0] lng);
    logic [CFG_DATA_W-2:0] junk;
    junk = (CFG_DATA_W-1)'($urandom);
    drain();
    write_reg(CFG_INVERT_INPUT, {junk, inv});
    write_reg(CFG_DEBOUNCE_TICKS, deb);
    write_reg(CFG_LONG_PRESS_TICKS, lng);
    write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
    @(negedge clk) cfg_we <= 1'b0;
  endtask

  // Random settings, then mostly well-formed level runs long enough to be
  // accepted (with press lengths straddling the long threshold), some bounce
  // runs that stop at or just past the debounce window, and bursts of noise.
  task automatic random_phase(input int n_items, input bit hold_midway);
    logic               inv;
    logic               lvl;
    logic [TICKS_W-1:0] deb;
    logic [TICKS_W-1:0] lng;
    int                 sent;
    int                 run_len;
    inv = ($urandom_range(0, 1) != 0);
    lvl = ($urandom_range(0, 1) != 0);
    case ($urandom_range(0, 3))
      0:       deb = '0;
      1:       deb = TICKS_W'($urandom_range(1, 3));
      default: deb = TICKS_W'($urandom_range(0, 8));
    endcase
    case ($urandom_range(0, 3))
      0:       lng = '0;
      1:       lng = TICKS_W'($urandom_range(1, 6));
      default: lng = TICKS_W'($urandom_range(7, 30));
    endcase
    apply_config(inv, deb, lng);
    sent = 0;
    while (sent < n_items) begin
      // Pause mid-stream until the block has caught up completely.
      if (hold_midway && sent >= n_items / 2) begin
        drain();
        hold_midway = 1'b0;
      end
      if ($urandom_range(0, 9) == 0) begin
        run_len = $urandom_range(1, 4);
        repeat (run_len) send_tick($urandom_range(0, 1) != 0);
      end else begin
        if ($urandom_range(0, 3) == 0) run_len = $urandom_range(1, deb + 2);
        else run_len = $urandom_range(deb + 2, deb + lng + 8);
        lvl = ~lvl;
        send_run(lvl, run_len);
      end
      sent += run_len;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Reset settings: inverted pin, 80-tick debounce, 1000-tick long press.
    // A pin high for 85 ticks is a press; low again for 85 gives a short one.
    send_run(1'b1, 85);
    send_run(1'b0, 85);

    // Directed: zero debounce, long threshold of three ticks.
    apply_config(1'b0, 16'd0, 16'd3);
    send_run(1'b0, 1);              // single-tick glitch, never accepted
    send_run(1'b1, 1);
    send_run(1'b0, 2);              // accepted on the second tick
    send_run(1'b1, 2);              // release one below threshold: short
    send_run(1'b0, 3);
    send_run(1'b1, 2);              // release exactly at threshold: long
    // Zero long threshold makes every release long.
    apply_config(1'b0, 16'd0, 16'd0);
    send_run(1'b0, 2);
    send_run(1'b1, 2);
    // Inverted pin again with a one-tick debounce window.
    apply_config(1'b1, 16'd1, 16'd3);
    send_run(1'b1, 3);
    send_run(1'b0, 3);

    for (int ph = 0; ph < 5; ph++) random_phase(100, ph == 2);

    // No idling from here on. With the debounce window at its maximum the
    // hold timer cannot exceed it, so a held level is never accepted.
    idle_en = 1'b0;
    apply_config(1'b0, 16'hFFFF, 16'hFFFF);
    send_run(1'b0, 40);

    random_phase(60, 1'b0);
    random_phase(60, 1'b0);

    @(negedge clk) raw_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_total == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/bdpc_pkg.sv
rtl/core/bdpc_cfg_regs.sv
rtl/core/bdpc_tracker.sv
rtl/core/button_debounce_press_classifier.sv
test/bdpc_checker.sv
test/button_debounce_press_classifier_tb.sv
